/* hdl/tsld_pkg.sv */
package tsld_pkg;

   // Frame layout
   localparam int unsigned TAG_BYTES       = 4;
   localparam int unsigned LEN_HIGH_OFFSET = 9;
   localparam int unsigned LEN_LOW_OFFSET  = 10;
   localparam int unsigned MIN_HEADER      = 11;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned TAG_W    = 32;
   localparam int unsigned LEN_W    = 7;
   localparam int unsigned OFFSET_W = 17;

   // Register map
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_TAG       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAILER_LENGTH = 2'd2;

   localparam logic [TAG_W-1:0] SYNC_TAG_RESET       = 32'd0;
   localparam logic [LEN_W-1:0] HEADER_LENGTH_RESET  = 7'd16;
   localparam logic [LEN_W-1:0] TRAILER_LENGTH_RESET = 7'd2;

   typedef struct packed {
      logic [TAG_W-1:0] sync_tag;
      logic [LEN_W-1:0] header_length;
      logic [LEN_W-1:0] trailer_length;
   } cfg_type;

   // One queued job: either a single pass-through byte or a whole tag run
   typedef struct packed {
      logic                is_tag;
      logic [TAG_W-1:0]    data;       // tag value, or byte in the low bits
      logic [OFFSET_W-1:0] offset;
      logic                frame_end;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* hdl/tsld_front.sv */
module tsld_front (
   input  logic                       clock,
   input  logic                       reset,
   input  tsld_pkg::cfg_type          cfg,
   input  logic                       accept,
   input  logic [tsld_pkg::BYTE_W-1:0] in_byte,
   output logic                       push,
   output tsld_pkg::entry_type        push_entry
);
   import tsld_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_BODY
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TAG_W-1:0]      window_ff, window_in;
   logic [2:0]            fill_ff, fill_in;
   logic [OFFSET_W-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0]     len_high_ff, len_high_in;
   logic [OFFSET_W-1:0]   total_ff, total_in;

   logic [LEN_W-1:0]      hdr_eff;
   logic                  hunting;
   logic [TAG_W-1:0]      win_shift;
   logic [2:0]            fill_next;
   logic                  match;
   logic [OFFSET_W-1:0]   total_now;
   logic [OFFSET_W:0]     pos_plus;
   logic                  frame_end;

   assign hdr_eff   = (cfg.header_length < LEN_W'(MIN_HEADER)) ?
                      LEN_W'(MIN_HEADER) : cfg.header_length;
   assign hunting   = (phase_ff != PH_HEADER) && (phase_ff != PH_BODY);
   assign win_shift = {window_ff[TAG_W-BYTE_W-1:0], in_byte};
   assign fill_next = (fill_ff < 3'(TAG_BYTES)) ? fill_ff + 3'd1 : fill_ff;
   assign match     = (fill_next == 3'(TAG_BYTES)) && (win_shift == cfg.sync_tag);
   assign pos_plus  = {1'b0, pos_ff} + (OFFSET_W+1)'(1);

   // length low byte lands in the same step that may close a short header
   assign total_now = (phase_ff == PH_HEADER && pos_ff == OFFSET_W'(LEN_LOW_OFFSET)) ?
                      OFFSET_W'(hdr_eff) + OFFSET_W'({len_high_ff, in_byte}) +
                      OFFSET_W'(cfg.trailer_length) : total_ff;

   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      len_high_in = len_high_ff;
      total_in    = total_ff;
      push        = 1'b0;
      frame_end   = 1'b0;
      push_entry  = '0;

      if (hunting) begin
         push_entry.is_tag = 1'b1;
         push_entry.data   = cfg.sync_tag;
      end else begin
         if (phase_ff == PH_HEADER) begin
            if (pos_plus >= (OFFSET_W+1)'(hdr_eff)) begin
               frame_end = (total_now <= OFFSET_W'(hdr_eff));
            end
         end else begin
            frame_end = (pos_plus >= {1'b0, total_ff});
         end
         push_entry.is_tag    = 1'b0;
         push_entry.data      = TAG_W'(in_byte);
         push_entry.offset    = pos_ff;
         push_entry.frame_end = frame_end;
      end

      if (accept) begin
         if (hunting) begin
            if (match) begin
               push        = 1'b1;
               window_in   = '0;
               fill_in     = '0;
               phase_in    = PH_HEADER;
               pos_in      = OFFSET_W'(TAG_BYTES);
               len_high_in = '0;
               total_in    = '0;
            end else begin
               window_in = win_shift;
               fill_in   = fill_next;
            end
         end else begin
            push = 1'b1;
            if (phase_ff == PH_HEADER) begin
               if (pos_ff == OFFSET_W'(LEN_HIGH_OFFSET)) begin
                  len_high_in = in_byte;
               end
               total_in = total_now;
               if (pos_plus >= (OFFSET_W+1)'(hdr_eff) && !frame_end) begin
                  phase_in = PH_BODY;
               end
            end
            if (frame_end) begin
               phase_in = PH_HUNT;
               pos_in   = '0;
            end else begin
               pos_in = pos_plus[OFFSET_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         window_ff   <= '0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         len_high_ff <= '0;
         total_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         len_high_ff <= len_high_in;
         total_ff    <= total_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (accept && hunting && match) |=> (phase_ff == PH_HEADER && pos_ff == OFFSET_W'(TAG_BYTES)))
      else $error("tag match did not open a header");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'(TAG_BYTES))
      else $error("window fill overran");

   assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.frame_end) |=> (phase_ff == PH_HUNT && pos_ff == '0))
      else $error("frame end did not return to hunting");

endmodule

/* hdl/tsld_queue.sv */
module tsld_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  tsld_pkg::entry_type           push_entry,
   input  logic                          pop,
   output tsld_pkg::entry_type           head,
   output tsld_pkg::queue_status_type    status
);
   import tsld_pkg::*;

   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   entry_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == COUNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

endmodule

/* hdl/tsld_back.sv */
module tsld_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tsld_pkg::entry_type           head,
   input  tsld_pkg::queue_status_type    status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsld_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [tsld_pkg::OFFSET_W-1:0] rsp_byte_offset,
   output logic                          rsp_frame_start,
   output logic                          rsp_frame_end,
   output logic                          rsp_run_last
);
   import tsld_pkg::*;

   logic                 valid_ff, valid_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic                 start_ff, start_in;
   logic                 end_ff, end_in;
   logic                 last_ff, last_in;
   logic                 busy_ff, busy_in;    // expanding a tag run
   logic [1:0]           beat_ff, beat_in;    // next tag byte index
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic                 load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      offset_in = offset_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      last_in   = last_ff;
      busy_in   = busy_ff;
      beat_in   = beat_ff;
      tag_in    = tag_ff;
      pop       = 1'b0;
      if (load) begin
         if (busy_ff) begin
            valid_in  = 1'b1;
            byte_in   = tag_ff[{~beat_ff, 3'b000} +: BYTE_W];
            offset_in = OFFSET_W'(beat_ff);
            start_in  = 1'b0;
            end_in    = 1'b0;
            last_in   = (beat_ff == 2'd3);
            busy_in   = (beat_ff != 2'd3);
            beat_in   = beat_ff + 2'd1;
         end else if (!status.empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head.is_tag) begin
               byte_in   = head.data[TAG_W-1 -: BYTE_W];
               offset_in = '0;
               start_in  = 1'b1;
               end_in    = 1'b0;
               last_in   = 1'b0;
               busy_in   = 1'b1;
               beat_in   = 2'd1;
               tag_in    = head.data;
            end else begin
               byte_in   = head.data[BYTE_W-1:0];
               offset_in = head.offset;
               start_in  = 1'b0;
               end_in    = head.frame_end;
               last_in   = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         beat_ff  <= beat_in;
      end
      byte_ff   <= byte_in;
      offset_ff <= offset_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      last_ff   <= last_in;
      tag_ff    <= tag_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_frame_start = start_ff;
   assign rsp_frame_end   = end_ff;
   assign rsp_run_last    = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> valid_ff)
      else $error("tag run in progress without a word on the output");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && start_ff) |-> (offset_ff == '0 && !end_ff && !last_ff))
      else $error("bad frame start word");

endmodule

/* hdl/tag_sync_length_deframer.sv */
// Channel  Direction  Handshake             Word
// req      in         req_valid/req_stall   req_in_byte
// rsp      out        rsp_valid/rsp_stall   out_byte, byte_offset, frame_start/end, run_last
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One byte accepted per cycle while req_stall is low; a tag match queues a single job.
// A passed byte is written into the job queue and then loaded into the back-end output register,
// after any jobs waiting ahead of it.
// A tag match turns one input byte into four rsp words from the back end.
// req_stall rises only when the QUEUE_DEPTH-entry job queue is full.
// Synchronous active-high reset; no clearing pass, ready right after reset.
// csr_ready is always high; writes to an unused index are dropped.
module tag_sync_length_deframer #(
   parameter int unsigned QUEUE_DEPTH = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tsld_pkg::BYTE_W-1:0]         req_in_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tsld_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic [tsld_pkg::OFFSET_W-1:0]       rsp_byte_offset,
   output logic                                rsp_frame_start,
   output logic                                rsp_frame_end,
   output logic                                rsp_run_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tsld_pkg::TAG_W-1:0]          csr_data
);
   import tsld_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              accept;
   logic              push;
   logic              pop;
   entry_type         push_entry;
   entry_type         head;
   queue_status_type  status;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_TAG:       cfg_in.sync_tag       = csr_data;
            CSR_HEADER_LENGTH:  cfg_in.header_length  = csr_data[LEN_W-1:0];
            CSR_TRAILER_LENGTH: cfg_in.trailer_length = csr_data[LEN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_tag       <= SYNC_TAG_RESET;
         cfg_ff.header_length  <= HEADER_LENGTH_RESET;
         cfg_ff.trailer_length <= TRAILER_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: hunt, header and body tracking; one job per emitting byte
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   tsld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   // job queue soaks up the four-word tag burst
   tsld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   // back end: expands jobs into rsp words behind an output register
   tsld_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last)
   );

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled rsp word dropped");

endmodule
